>>> sv/aligned_write_splitter_assert.svh
// assertion macros shared by the aligned write splitter modules
`ifndef ALIGNED_WRITE_SPLITTER_ASSERT_SVH
`define ALIGNED_WRITE_SPLITTER_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define AWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define AWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/aws_pkg.sv
// shared types and constants for the aligned write splitter
package aws_pkg;

  // transfer limits and field widths
  localparam int MAX_BYTES   = 64;
  localparam int CNT_W       = 7;
  localparam int CHUNK_BYTES = 8;
  localparam int CHUNK_W     = 4;
  localparam int ADDR_W      = 32;
  localparam int CORE_ID_W   = 12;
  localparam int LOCAL_SHIFT = 20;

  localparam logic [CORE_ID_W-1:0] CORE_ID_RESET = 12'd2056;
  localparam logic [CNT_W-1:0]     MAX_COUNT     = CNT_W'(MAX_BYTES);
  localparam logic [CNT_W-1:0]     CHUNK_COUNT   = CNT_W'(CHUNK_BYTES);

  // write control byte of a mesh packet
  typedef enum logic [2:0] {
    MODE_BYTE   = 3'd1,
    MODE_HALF   = 3'd3,
    MODE_WORD   = 3'd5,
    MODE_DOUBLE = 3'd7
  } mode_t;

  // request item
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] dest_address;
    logic [ADDR_W-1:0] source_address;
    logic [CNT_W-1:0]  byte_count;
  } req_t;

  // packet item
  typedef struct packed {
    logic [ADDR_W-1:0] packet_address;
    logic [ADDR_W-1:0] payload_address;
    logic [2:0]        mode_code;
    logic              zero_payload;
    logic              last_packet;
  } pkt_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic last;
  } stat_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // byte size of a packet mode
  function automatic logic [CNT_W-1:0] mode_bytes(input mode_t mode);
    logic [CNT_W-1:0] bytes;
    case (mode)
      MODE_BYTE:   bytes = CNT_W'(1);
      MODE_HALF:   bytes = CNT_W'(2);
      MODE_WORD:   bytes = CNT_W'(4);
      MODE_DOUBLE: bytes = CNT_W'(8);
      default:     bytes = CNT_W'(1);
    endcase
    return bytes;
  endfunction

endpackage

>>> sv/aws_ctrl.sv
// controller state machine of the aligned write splitter
module aws_ctrl
  import aws_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (!stat.empty) begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        if (stat.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `include "aligned_write_splitter_assert.svh"

  `AWS_ASSERT_NEXT(a_last_ends_run, cmd.step && stat.last, state == ST_IDLE, "run did not end on last packet")
  `AWS_ASSERT_NEXT(a_load_starts_run, cmd.load && !stat.empty, state == ST_RUN, "nonempty item did not start a run")

endmodule

>>> sv/aws_dp.sv
// datapath of the aligned write splitter: address, count and packet size
module aws_dp
  import aws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CORE_ID_W-1:0] cfg_wr_data,
  input  req_t                 request,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output pkt_t                 result
);

  logic [CORE_ID_W-1:0] core_id;
  logic                 clear;
  logic [ADDR_W-1:0]    dst;
  logic [ADDR_W-1:0]    src;
  logic [CNT_W-1:0]     remain;
  logic [CHUNK_W-1:0]   chunk;

  logic [CNT_W-1:0]     sat_count;
  logic [ADDR_W-1:0]    reloc_dst;
  logic [CNT_W-1:0]     avail;
  logic [1:0]           diff;
  mode_t                mode;
  logic [CNT_W-1:0]     size;
  logic [CNT_W-1:0]     remain_next;
  logic                 chunk_end;

  // core id register
  always_ff @(posedge clk) begin
    if (rst) begin
      core_id <= CORE_ID_RESET;
    end else if (cfg_wr_en) begin
      core_id <= cfg_wr_data;
    end
  end

  // saturate count and relocate a local destination
  always_comb begin
    sat_count = (request.byte_count > MAX_COUNT) ? MAX_COUNT : request.byte_count;
    reloc_dst = request.dest_address;
    if (request.dest_address[ADDR_W-1:LOCAL_SHIFT] == '0) begin
      reloc_dst[ADDR_W-1:LOCAL_SHIFT] = core_id;
    end
  end

  // packet size from shared alignment and bytes left in this split
  always_comb begin
    avail = clear ? CNT_W'(chunk) : remain;
    diff  = dst[1:0] ^ src[1:0];
    mode  = MODE_BYTE;
    if (diff[0] || dst[0]) begin
      mode = MODE_BYTE;
    end else if (diff[1] || dst[1]) begin
      mode = (avail > CNT_W'(1)) ? MODE_HALF : MODE_BYTE;
    end else if (avail >= CNT_W'(8)) begin
      mode = MODE_DOUBLE;
    end else if (avail >= CNT_W'(4)) begin
      mode = MODE_WORD;
    end else if (avail >= CNT_W'(2)) begin
      mode = MODE_HALF;
    end
    size        = mode_bytes(mode);
    remain_next = remain - size;
    chunk_end   = (CNT_W'(chunk) == size);
  end

  // transfer registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clear  <= request.kind;
      dst    <= reloc_dst;
      src    <= request.kind ? '0 : request.source_address;
      remain <= sat_count;
      chunk  <= (sat_count > CHUNK_COUNT) ? CHUNK_W'(CHUNK_BYTES) : sat_count[CHUNK_W-1:0];
    end else if (cmd.step) begin
      dst    <= dst + ADDR_W'(size);
      remain <= remain_next;
      if (clear && chunk_end) begin
        // next clear chunk restarts from an 8-aligned zero source
        src   <= '0;
        chunk <= (remain_next > CHUNK_COUNT) ? CHUNK_W'(CHUNK_BYTES)
                                             : remain_next[CHUNK_W-1:0];
      end else begin
        src   <= src + ADDR_W'(size);
        chunk <= chunk - size[CHUNK_W-1:0];
      end
    end
  end

  // status and packet fields
  always_comb begin
    stat.empty             = (sat_count == '0);
    stat.last              = (remain == size);
    result.packet_address  = dst;
    result.payload_address = clear ? '0 : src;
    result.mode_code       = mode;
    result.zero_payload    = clear;
    result.last_packet     = (remain == size);
  end

  `include "aligned_write_splitter_assert.svh"

  `AWS_ASSERT_NOW(a_no_underflow, cmd.step, remain >= size, "packet larger than bytes left")
  `AWS_ASSERT_NOW(a_wide_aligned, cmd.step && (mode == MODE_WORD || mode == MODE_DOUBLE), dst[1:0] == 2'b00, "word packet not word aligned")
  `AWS_ASSERT_NOW(a_chunk_live, cmd.step && clear, chunk != '0 && CNT_W'(chunk) >= size, "clear chunk exhausted")

endmodule

>>> sv/aligned_write_splitter.sv
// top level of the aligned write splitter
//
//  channel   direction  handshake               payload
//  request   in         start high, busy low    req_t
//  result    out        result_strobe one cycle pkt_t
//  config    in         cfg_wr_en               cfg_wr_data (core id)
//
// an item is taken on start while idle, then one packet leaves per cycle;
// packets per item range 0..64 (8 for a clear of 64 aligned bytes, 64 for
// unaligned byte copies). busy is high while packets remain.
// synchronous reset idles the block and sets core id to 2056.
// results cannot be stalled; a zero byte count returns to idle at once.
module aligned_write_splitter
  import aws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 request,
  input  logic                 cfg_wr_en,
  input  logic [CORE_ID_W-1:0] cfg_wr_data,
  output logic                 result_strobe,
  output pkt_t                 result
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  aws_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // addresses and packet sizes
  aws_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .request     (request),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result)
  );

  // one packet per step cycle
  assign result_strobe = cmd.step;

endmodule
